>>> hdl/hts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_pkg: shared types, constants and functions of the HTML tag stripper
// Holds the channel word types, register indexes, character codes and the
// case-insensitive tag name compare.
// ----------------------------------------------------------------------------
package hts_pkg;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_string;
    } in_word_t;

    typedef struct packed {
        logic       space_before;
        logic       char_valid;
        logic [7:0] out_char;
        logic       string_done;
    } out_word_t;

    typedef struct packed {
        logic strip_hit;
        logic active_eq;
    } match_t;

    localparam int NAME_BITS = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int MAX_SLOTS = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_EMIT_SPACES = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_RESET  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_COUNT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_TAG_0 = 3'd3;

    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    // Names end at their first zero byte; bytes after it are not compared.
    function automatic logic names_equal(input logic [NAME_BITS-1:0] a,
                                         input logic [NAME_BITS-1:0] b);
        logic       ok;
        logic       done;
        logic [7:0] x;
        logic [7:0] y;
        ok   = 1'b1;
        done = 1'b0;
        for (int i = 0; i < NAME_BITS / 8; i++)
        begin
            x = to_lower(a[8*i +: 8]);
            y = to_lower(b[8*i +: 8]);
            if (!done)
            begin
                if (x != y)
                begin
                    ok   = 1'b0;
                    done = 1'b1;
                end
                else if (x == 8'd0)
                begin
                    done = 1'b1;
                end
            end
        end
        return ok;
    endfunction

endpackage

>>> hdl/hts_name_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_name_match: tag name compare unit
// Compares the captured tag name against the configured strip tags in use
// and against the remembered strip name, all in parallel.
// ----------------------------------------------------------------------------
module hts_name_match #(
    parameter int STRIP_SLOTS = 4
) (
    input  logic [hts_pkg::NAME_BITS-1:0]                  name,
    input  logic [hts_pkg::NAME_BITS-1:0]                  active_name,
    input  logic [STRIP_SLOTS-1:0][hts_pkg::NAME_BITS-1:0] strip_tags,
    input  logic [2:0]                                     strip_count,
    output hts_pkg::match_t                                result
);

    logic [STRIP_SLOTS-1:0] slot_hit;

    always_comb
    begin
        for (int i = 0; i < STRIP_SLOTS; i++)
        begin
            slot_hit[i] = (3'(i) < strip_count) &&
                          hts_pkg::names_equal(name, strip_tags[i]);
        end
        result.strip_hit = |slot_hit;
        result.active_eq = hts_pkg::names_equal(active_name, name);
    end

endmodule

>>> hdl/html_tag_stripper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_tag_stripper: streaming HTML to text filter
// Takes one HTML byte per word and returns one result word per byte.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_data) carries one raw byte and an
// end-of-string mark per word. Every accepted word yields exactly one result
// word on the output channel (out_valid, out_ready, out_data): the text byte
// with char_valid set when it lies outside tags and strip blocks, a flag for
// an inserted space, and a copy of the end-of-string mark.
// The parser state and the result register both load at the accepting edge,
// so the result is offered in the next cycle. Throughput is one word per cycle
// while not stalled; the single parser pass and parallel name compare set it.
// When the receiver stalls, the result register holds its word and in_ready
// drops until that word is taken; a word is accepted in the same cycle the
// held one leaves.
// Reset clears the parser state and loads the register reset values (spaces
// on, auto reset on, no strip tags). The user must write registers through
// cfg_we, cfg_index, cfg_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module html_tag_stripper #(
    parameter int NAME_CHARS  = 8,
    parameter int STRIP_SLOTS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  hts_pkg::in_word_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output hts_pkg::out_word_t                 out_data,
    input  logic                               cfg_we,
    input  logic [hts_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NL_W = $clog2(NAME_CHARS + 1);

    // Configuration registers.
    logic                                          emit_spaces_reg;
    logic                                          auto_reset_reg;
    logic [2:0]                                    strip_count_reg;
    logic [STRIP_SLOTS-1:0][hts_pkg::NAME_BITS-1:0] strip_tag_reg;

    // Parser state.
    logic inside_tag_reg,     inside_tag_next;
    logic closing_tag_reg,    closing_tag_next;
    logic name_complete_reg,  name_complete_next;
    logic just_saw_tag_reg,   just_saw_tag_next;
    logic space_emitted_reg,  space_emitted_next;
    logic prev_slash_reg,     prev_slash_next;
    logic prev_minus_reg,     prev_minus_next;
    logic in_decl_reg,        in_decl_next;
    logic in_remark_reg,      in_remark_next;
    logic in_strip_reg,       in_strip_next;
    logic in_quoted_reg,      in_quoted_next;
    logic quote_double_reg,   quote_double_next;
    logic [hts_pkg::NAME_BITS-1:0] name_buf_reg,    name_buf_next;
    logic [NL_W-1:0]               name_len_reg,    name_len_next;
    logic [hts_pkg::NAME_BITS-1:0] active_name_reg, active_name_next;

    logic               out_valid_reg;
    hts_pkg::out_word_t out_data_reg;
    hts_pkg::out_word_t result;

    hts_pkg::match_t match;
    logic            accept;
    logic [7:0]      c;
    logic            run_tag_end;
    logic            tag_end_eq;
    logic            c_space;
    logic [2:0]      ins_idx;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign c         = in_data.in_char;
    assign c_space   = hts_pkg::is_space(c);
    assign ins_idx   = 3'(name_len_reg);

    hts_name_match #(
        .STRIP_SLOTS(STRIP_SLOTS)
    ) u_match (
        .name        (name_buf_reg),
        .active_name (active_name_reg),
        .strip_tags  (strip_tag_reg),
        .strip_count (strip_count_reg),
        .result      (match)
    );

    always_comb
    begin
        inside_tag_next    = inside_tag_reg;
        closing_tag_next   = closing_tag_reg;
        name_complete_next = name_complete_reg;
        just_saw_tag_next  = just_saw_tag_reg;
        space_emitted_next = space_emitted_reg;
        prev_slash_next    = prev_slash_reg;
        prev_minus_next    = prev_minus_reg;
        in_decl_next       = in_decl_reg;
        in_remark_next     = in_remark_reg;
        in_strip_next      = in_strip_reg;
        in_quoted_next     = in_quoted_reg;
        quote_double_next  = quote_double_reg;
        name_buf_next      = name_buf_reg;
        name_len_next      = name_len_reg;
        active_name_next   = active_name_reg;

        result.space_before = 1'b0;
        result.char_valid   = 1'b0;
        result.out_char     = 8'd0;
        result.string_done  = in_data.end_of_string;

        run_tag_end = 1'b0;
        tag_end_eq  = match.active_eq;

        if (inside_tag_reg)
        begin
            if (!name_complete_reg && !in_decl_reg)
            begin
                if (name_len_reg == '0 && c == hts_pkg::CH_BANG)
                begin
                    in_decl_next = 1'b1;
                end
                else if (name_len_reg == '0 && c == hts_pkg::CH_SLASH)
                begin
                    closing_tag_next = 1'b1;
                end
                else if (!in_strip_reg || closing_tag_reg)
                begin
                    if (!c_space && c != hts_pkg::CH_SLASH && c != hts_pkg::CH_GT &&
                        name_len_reg < NL_W'(NAME_CHARS))
                    begin
                        name_buf_next[8*ins_idx +: 8] = name_buf_reg[8*ins_idx +: 8] | c;
                        name_len_next = name_len_reg + NL_W'(1);
                    end
                    else
                    begin
                        // The name ends here; this byte may also end the tag.
                        name_complete_next = 1'b1;
                        if (in_strip_reg && closing_tag_reg)
                        begin
                            if (match.active_eq)
                            begin
                                in_strip_next = 1'b0;
                            end
                        end
                        else if (!in_strip_reg && !closing_tag_reg && match.strip_hit)
                        begin
                            in_strip_next    = 1'b1;
                            active_name_next = name_buf_reg;
                            tag_end_eq       = 1'b1;
                        end
                        run_tag_end = 1'b1;
                    end
                end
            end
            else if (in_quoted_reg)
            begin
                if (c == (quote_double_reg ? hts_pkg::CH_DQUOTE : hts_pkg::CH_SQUOTE))
                begin
                    in_quoted_next = 1'b0;
                end
            end
            else if (!in_remark_reg &&
                     (c == hts_pkg::CH_SQUOTE || c == hts_pkg::CH_DQUOTE))
            begin
                in_quoted_next    = 1'b1;
                quote_double_next = (c == hts_pkg::CH_DQUOTE);
                prev_minus_next   = 1'b0;
                prev_slash_next   = 1'b0;
            end
            else if (in_decl_reg)
            begin
                // A pair of minus signs opens or closes a comment.
                if (prev_minus_reg)
                begin
                    if (c == hts_pkg::CH_MINUS)
                    begin
                        in_remark_next = !in_remark_reg;
                    end
                    prev_minus_next = 1'b0;
                end
                else if (c == hts_pkg::CH_MINUS)
                begin
                    prev_minus_next = 1'b1;
                end
                run_tag_end = !in_remark_next;
            end
            else
            begin
                run_tag_end = 1'b1;
            end
        end
        else if (c == hts_pkg::CH_LT)
        begin
            inside_tag_next    = 1'b1;
            name_buf_next      = '0;
            name_len_next      = '0;
            name_complete_next = 1'b0;
            closing_tag_next   = 1'b0;
            just_saw_tag_next  = 1'b1;
        end
        else if (!in_strip_reg)
        begin
            result.space_before = emit_spaces_reg && !c_space &&
                                  !space_emitted_reg && just_saw_tag_reg;
            result.char_valid   = 1'b1;
            result.out_char     = c;
            just_saw_tag_next   = 1'b0;
            space_emitted_next  = c_space;
        end

        if (run_tag_end)
        begin
            if (c == hts_pkg::CH_SLASH)
            begin
                prev_slash_next = 1'b1;
            end
            else
            begin
                if (c == hts_pkg::CH_GT)
                begin
                    in_quoted_next  = 1'b0;
                    in_remark_next  = 1'b0;
                    in_decl_next    = 1'b0;
                    inside_tag_next = 1'b0;
                    if (prev_slash_next && tag_end_eq)
                    begin
                        in_strip_next = 1'b0;
                    end
                end
                prev_slash_next = 1'b0;
            end
        end

        if (in_data.end_of_string && auto_reset_reg)
        begin
            inside_tag_next    = 1'b0;
            closing_tag_next   = 1'b0;
            prev_slash_next    = 1'b0;
            name_complete_next = 1'b0;
            space_emitted_next = 1'b1;
            just_saw_tag_next  = 1'b0;
            in_quoted_next     = 1'b0;
            in_decl_next       = 1'b0;
            in_remark_next     = 1'b0;
            prev_minus_next    = 1'b0;
            in_strip_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_spaces_reg   <= 1'b1;
            auto_reset_reg    <= 1'b1;
            strip_count_reg   <= 3'd0;
            strip_tag_reg     <= '0;
            inside_tag_reg    <= 1'b0;
            closing_tag_reg   <= 1'b0;
            name_complete_reg <= 1'b0;
            just_saw_tag_reg  <= 1'b0;
            space_emitted_reg <= 1'b1;
            prev_slash_reg    <= 1'b0;
            prev_minus_reg    <= 1'b0;
            in_decl_reg       <= 1'b0;
            in_remark_reg     <= 1'b0;
            in_strip_reg      <= 1'b0;
            in_quoted_reg     <= 1'b0;
            quote_double_reg  <= 1'b0;
            name_buf_reg      <= '0;
            name_len_reg      <= '0;
            active_name_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    hts_pkg::CFG_EMIT_SPACES: emit_spaces_reg <= cfg_data[0];
                    hts_pkg::CFG_AUTO_RESET:  auto_reset_reg  <= cfg_data[0];
                    hts_pkg::CFG_STRIP_COUNT:
                    begin
                        // Counts above the slot count use every slot.
                        if (cfg_data[2:0] > 3'(STRIP_SLOTS))
                        begin
                            strip_count_reg <= 3'(STRIP_SLOTS);
                        end
                        else
                        begin
                            strip_count_reg <= cfg_data[2:0];
                        end
                    end
                    default:
                    begin
                        for (int i = 0; i < STRIP_SLOTS; i++)
                        begin
                            if (cfg_index == hts_pkg::CFG_STRIP_TAG_0 + 3'(i))
                            begin
                                strip_tag_reg[i] <= cfg_data;
                            end
                        end
                    end
                endcase
            end

            if (accept)
            begin
                inside_tag_reg    <= inside_tag_next;
                closing_tag_reg   <= closing_tag_next;
                name_complete_reg <= name_complete_next;
                just_saw_tag_reg  <= just_saw_tag_next;
                space_emitted_reg <= space_emitted_next;
                prev_slash_reg    <= prev_slash_next;
                prev_minus_reg    <= prev_minus_next;
                in_decl_reg       <= in_decl_next;
                in_remark_reg     <= in_remark_next;
                in_strip_reg      <= in_strip_next;
                in_quoted_reg     <= in_quoted_next;
                quote_double_reg  <= quote_double_next;
                name_buf_reg      <= name_buf_next;
                name_len_reg      <= name_len_next;
                active_name_reg   <= active_name_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

endmodule

>>> tb/html_text_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_text_checker: result predictor and comparator for the tag stripper
// Watches the byte, result and register ports, keeps its own copy of the
// parser state and register settings, predicts one result word per accepted
// byte and compares every accepted result word field by field.
// ----------------------------------------------------------------------------
module html_text_checker #(
    parameter int NAME_CHARS  = 8,
    parameter int STRIP_SLOTS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  hts_pkg::in_word_t                  in_data,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  hts_pkg::out_word_t                 out_data,
    input  logic                               cfg_we,
    input  logic [hts_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 mismatches,
    output int                                 outstanding
);
    import hts_pkg::*;

    // Register copies.
    logic        spaces_on;
    logic        auto_clear;
    logic [2:0]  slot_count;
    logic [63:0] tag_cfg [MAX_SLOTS];

    // Parser copy.
    logic        in_tag;
    logic        closing;
    logic        name_done;
    logic        tag_seen;
    logic        space_out;
    logic        slash_seen;
    logic        minus_seen;
    logic        in_decl;
    logic        in_remark;
    logic        stripping;
    logic        quoted;
    logic        dquote;
    logic [63:0] name_buf;
    int unsigned name_len;
    logic [63:0] strip_name;

    out_word_t   expected_text [$];
    int          fail_total = 0;

    assign mismatches = fail_total;

    function automatic logic blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    // Names stop at their first zero byte.
    function automatic logic same_name(input logic [63:0] a, input logic [63:0] b);
        logic [7:0] x;
        logic [7:0] y;
        for (int i = 0; i < 8; i++)
        begin
            x = fold_case(a[8*i +: 8]);
            y = fold_case(b[8*i +: 8]);
            if (x != y)
                return 1'b0;
            if (x == 8'd0)
                return 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic clear_parser();
        in_tag     = 1'b0;
        closing    = 1'b0;
        slash_seen = 1'b0;
        name_done  = 1'b0;
        space_out  = 1'b1;
        tag_seen   = 1'b0;
        quoted     = 1'b0;
        in_decl    = 1'b0;
        in_remark  = 1'b0;
        minus_seen = 1'b0;
        stripping  = 1'b0;
    endtask

    task automatic tag_end(input logic [7:0] c);
        if (c == CH_SLASH)
        begin
            slash_seen = 1'b1;
        end
        else
        begin
            if (c == CH_GT)
            begin
                quoted    = 1'b0;
                in_remark = 1'b0;
                in_decl   = 1'b0;
                in_tag    = 1'b0;
                // A self-closed tag of the remembered name ends the strip block.
                if (slash_seen && same_name(strip_name, name_buf))
                    stripping = 1'b0;
            end
            slash_seen = 1'b0;
        end
    endtask

    task automatic close_name(input logic [7:0] c);
        int n;
        name_done = 1'b1;
        if (stripping && closing)
        begin
            if (same_name(name_buf, strip_name))
                stripping = 1'b0;
        end
        else if (!stripping && !closing)
        begin
            n = (slot_count > STRIP_SLOTS) ? STRIP_SLOTS : int'(slot_count);
            for (int i = 0; i < n; i++)
            begin
                if (same_name(name_buf, tag_cfg[i]))
                begin
                    stripping  = 1'b1;
                    strip_name = name_buf;
                end
            end
        end
        tag_end(c);
    endtask

    task automatic filter_byte(input in_word_t w, output out_word_t r);
        logic [7:0] c;
        c = w.in_char;
        r = '0;
        if (in_tag)
        begin
            if (!name_done && !in_decl)
            begin
                if (name_len == 0 && c == CH_BANG)
                    in_decl = 1'b1;
                else if (name_len == 0 && c == CH_SLASH)
                    closing = 1'b1;
                else if (!stripping || closing)
                begin
                    if (!blank(c) && c != CH_SLASH && c != CH_GT && name_len < NAME_CHARS)
                    begin
                        name_buf = name_buf | ({56'd0, c} << (8 * name_len));
                        name_len++;
                    end
                    else
                    begin
                        close_name(c);
                    end
                end
            end
            else if (quoted)
            begin
                if (c == (dquote ? CH_DQUOTE : CH_SQUOTE))
                    quoted = 1'b0;
            end
            else if (!in_remark && (c == CH_SQUOTE || c == CH_DQUOTE))
            begin
                quoted     = 1'b1;
                dquote     = (c == CH_DQUOTE);
                minus_seen = 1'b0;
                slash_seen = 1'b0;
            end
            else if (in_decl)
            begin
                // Two minus signs in a row toggle the comment inside a declaration.
                if (minus_seen)
                begin
                    if (c == CH_MINUS)
                        in_remark = !in_remark;
                    minus_seen = 1'b0;
                end
                else if (c == CH_MINUS)
                begin
                    minus_seen = 1'b1;
                end
                if (!in_remark)
                    tag_end(c);
            end
            else
            begin
                tag_end(c);
            end
        end
        else if (c == CH_LT)
        begin
            in_tag    = 1'b1;
            name_buf  = '0;
            name_len  = 0;
            name_done = 1'b0;
            closing   = 1'b0;
            tag_seen  = 1'b1;
        end
        else if (!stripping)
        begin
            if (spaces_on && !blank(c) && !space_out && tag_seen)
            begin
                r.space_before = 1'b1;
                space_out      = 1'b1;
            end
            r.char_valid = 1'b1;
            r.out_char   = c;
            tag_seen     = 1'b0;
            space_out    = blank(c);
        end
        if (w.end_of_string && auto_clear)
            clear_parser();
        r.string_done = w.end_of_string;
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            fail_total++;
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        out_word_t next_want;
        if (!rst_n)
        begin
            clear_parser();
            dquote      = 1'b0;
            name_buf    = '0;
            name_len    = 0;
            strip_name  = '0;
            spaces_on   = 1'b1;
            auto_clear  = 1'b1;
            slot_count  = '0;
            for (int i = 0; i < MAX_SLOTS; i++)
                tag_cfg[i] = '0;
            expected_text.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    fail_total++;
                    $display("%0t: result word expected none actual %h", $time, out_data);
                end
                else
                begin
                    want = expected_text.pop_front();
                    check_field("space_before", 8'(want.space_before), 8'(out_data.space_before));
                    check_field("char_valid", 8'(want.char_valid), 8'(out_data.char_valid));
                    check_field("out_char", want.out_char, out_data.out_char);
                    check_field("string_done", 8'(want.string_done), 8'(out_data.string_done));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EMIT_SPACES: spaces_on  = cfg_data[0];
                    CFG_AUTO_RESET:  auto_clear = cfg_data[0];
                    CFG_STRIP_COUNT: slot_count = cfg_data[2:0];
                    default:
                    begin
                        if (cfg_index >= CFG_STRIP_TAG_0 &&
                            int'(cfg_index) < int'(CFG_STRIP_TAG_0) + MAX_SLOTS)
                            tag_cfg[cfg_index - CFG_STRIP_TAG_0] = cfg_data;
                    end
                endcase
            end
            if (in_valid && in_ready)
            begin
                filter_byte(in_data, next_want);
                expected_text.push_back(next_want);
            end
            outstanding <= expected_text.size();
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the HTML tag stripper
// Feeds short directed byte strings and then random HTML built from text,
// tags, closing tags, declarations and noise, under several register
// settings and idle patterns. A checker beside the block predicts and
// compares every result word.
// ----------------------------------------------------------------------------
module testbench;
    import hts_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int PHASE_BYTES = 100;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_word_t               in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_word_t              out_data;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int          mismatches;
    int          outstanding;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          quiet_cycles = 0;
    logic [63:0] tag_bits [MAX_SLOTS];
    logic [7:0]  html_bytes [$];

    html_tag_stripper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    html_text_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [63:0] name_bits(input string s);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < 8; i++)
            v[8*i +: 8] = s[i];
        return v;
    endfunction

    function automatic string pick_word(input int k);
        case (k)
            0: return "script";
            1: return "style";
            2: return "textarea";
            3: return "noscript";
            4: return "b";
            5: return "pre";
            6: return "title";
            7: return "xmp";
            default: return "iframe";
        endcase
    endfunction

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = 8'h61 + 8'($urandom_range(25));
        if ($urandom_range(1) == 1)
            c = c ^ 8'h20;
        return c;
    endfunction

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Writes every register, strip names from tag_bits, plus the unused index.
    task automatic program_regs(input logic emit, input logic clear, input logic [2:0] count);
        put_reg(CFG_EMIT_SPACES, 64'(emit));
        put_reg(CFG_AUTO_RESET, 64'(clear));
        put_reg(CFG_STRIP_COUNT, 64'(count));
        for (int k = 0; k < MAX_SLOTS; k++)
            put_reg(CFG_STRIP_TAG_0 + 3'(k), tag_bits[k]);
        put_reg(CFG_UNUSED, {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(input in_word_t w);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_text(input string s, input logic eos);
        in_word_t w;
        for (int i = 0; i < s.len(); i++)
        begin
            w.in_char       = s[i];
            w.end_of_string = eos && (i == s.len() - 1);
            send_word(w);
        end
    endtask

    task automatic wait_empty();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            html_bytes.push_back(s[i]);
    endtask

    task automatic add_text();
        int n;
        int r;
        logic [7:0] c;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 55)
                c = random_letter();
            else if (r < 70)
                c = CH_SPACE;
            else if (r < 78)
                c = 8'($urandom_range(9, 13));
            else if (r < 88)
                c = 8'($urandom_range(128, 255));
            else
                c = 8'($urandom_range(255));
            html_bytes.push_back(c);
        end
    endtask

    task automatic add_name();
        int kind;
        logic [63:0] t;
        logic [7:0] c;
        kind = $urandom_range(9);
        if (kind < 5)
        begin
            // A configured strip name with random letter case.
            t = tag_bits[$urandom_range(MAX_SLOTS - 1)];
            for (int i = 0; i < 8; i++)
            begin
                c = t[8*i +: 8];
                if (c == 8'd0)
                    break;
                if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(1) == 1)
                    c = c ^ 8'h20;
                html_bytes.push_back(c);
            end
        end
        else if (kind < 8)
        begin
            repeat ($urandom_range(1, 5))
                html_bytes.push_back(random_letter());
        end
        else if (kind == 8)
        begin
            repeat ($urandom_range(9, 12))
                html_bytes.push_back(random_letter());
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                html_bytes.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic add_open();
        logic [7:0] q;
        html_bytes.push_back(CH_LT);
        add_name();
        if ($urandom_range(2) == 0)
        begin
            q = ($urandom_range(1) == 1) ? CH_DQUOTE : CH_SQUOTE;
            put_text(" id=");
            html_bytes.push_back(q);
            add_text();
            if ($urandom_range(1) == 1)
                html_bytes.push_back(CH_GT);
            html_bytes.push_back((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
            html_bytes.push_back(q);
        end
        if ($urandom_range(3) == 0)
            html_bytes.push_back(CH_SLASH);
        html_bytes.push_back(CH_GT);
    endtask

    task automatic add_close();
        html_bytes.push_back(CH_LT);
        html_bytes.push_back(CH_SLASH);
        add_name();
        if ($urandom_range(3) == 0)
            html_bytes.push_back(CH_SPACE);
        html_bytes.push_back(CH_GT);
    endtask

    task automatic add_decl();
        html_bytes.push_back(CH_LT);
        html_bytes.push_back(CH_BANG);
        case ($urandom_range(2))
            0: put_text("DOCTYPE html");
            1:
            begin
                put_text("--");
                add_text();
                html_bytes.push_back(CH_GT);
                put_text("--");
            end
            default:
            begin
                put_text(" x=");
                html_bytes.push_back(CH_DQUOTE);
                html_bytes.push_back(CH_GT);
                html_bytes.push_back(CH_DQUOTE);
            end
        endcase
        html_bytes.push_back(CH_GT);
    endtask

    task automatic add_fragment();
        int r;
        r = $urandom_range(99);
        if (r < 35)
        begin
            add_text();
        end
        else if (r < 60)
        begin
            add_open();
        end
        else if (r < 75)
        begin
            add_close();
        end
        else if (r < 83)
        begin
            add_decl();
        end
        else if (r < 90)
        begin
            repeat ($urandom_range(1, 3))
                html_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            add_open();
            add_text();
            add_close();
        end
    endtask

    initial
    begin
        int sent;
        in_word_t w;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings first, then strip names with a slot count above the limit.
        send_text("a<i>b", 1'b0);
        wait_empty();
        tag_bits[0] = name_bits("b");
        tag_bits[1] = name_bits("script");
        tag_bits[2] = name_bits("TEXTAREA");
        tag_bits[3] = '1;
        program_regs(1'b1, 1'b1, 3'd7);
        send_text("x<b>q</B>", 1'b0);
        send_text("<!-->-->", 1'b0);
        send_text("<b/>", 1'b1);

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_empty();
            case (phase)
                0:
                begin
                    tag_bits[0] = name_bits("script");
                    tag_bits[1] = name_bits("STYLE");
                    tag_bits[2] = name_bits("textarea");
                    tag_bits[3] = name_bits("b");
                    program_regs(1'b1, 1'b1, 3'd4);
                end
                1:
                begin
                    tag_bits[0] = name_bits("Title");
                    tag_bits[1] = name_bits("pre");
                    tag_bits[2] = name_bits("noscript");
                    tag_bits[3] = {$urandom, $urandom};
                    program_regs(1'b0, 1'b0, 3'd7);
                end
                2:
                begin
                    tag_bits[0] = '0;
                    tag_bits[1] = '1;
                    tag_bits[2] = name_bits("script");
                    tag_bits[3] = name_bits("p");
                    program_regs(1'b1, 1'b0, 3'd0);
                end
                3:
                begin
                    tag_bits[0] = name_bits("style");
                    tag_bits[1] = name_bits("xmp");
                    tag_bits[2] = name_bits("iframe");
                    tag_bits[3] = name_bits("title");
                    program_regs(1'b0, 1'b1, 3'd1);
                end
                default:
                begin
                    for (int k = 0; k < MAX_SLOTS; k++)
                        tag_bits[k] = name_bits(pick_word($urandom_range(8)));
                    program_regs(1'($urandom_range(1)), 1'($urandom_range(1)),
                                 3'($urandom_range(7)));
                end
            endcase
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
                default: begin sender_idle_pct = 34; receiver_stall_pct = 34; end
            endcase

            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                html_bytes.delete();
                repeat ($urandom_range(1, 8))
                    add_fragment();
                // Strings mostly end after whole fragments; a few end at a random byte.
                for (int i = 0; i < html_bytes.size(); i++)
                begin
                    w.in_char       = html_bytes[i];
                    w.end_of_string = (i == html_bytes.size() - 1) ||
                                      ($urandom_range(99) < 2);
                    send_word(w);
                    sent++;
                end
            end
        end

        wait_empty();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
